// File: src/assert_macros.svh
// Assertion macros for the top-level RTL file; clocked on clk, disabled in rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// cond must never be true
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

// File: src/utbd_pkg.sv
// Package for the radix converter: widths, register map, shared types and helpers.
`timescale 1ns / 1ps

package utbd_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int COUNT_W        = 7;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // word index of the radix register (byte address 0)
  localparam logic REG_RADIX = 1'b0;

  localparam logic [CHAR_W-1:0] CHAR_ZERO   = 7'd48;  // '0'
  localparam logic [CHAR_W-1:0] CHAR_LETTER = 7'd55;  // 'A' - 10
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic quot_nz;
  } div_stat_t;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_DIGITS) begin
      res = CHAR_ZERO + {1'b0, d};
    end else begin
      res = CHAR_LETTER + {1'b0, d};
    end
    return res;
  endfunction

endpackage

// File: src/utbd_div.sv
// Bit-serial restoring divider: one quotient bit per cycle, small divisor.
`timescale 1ns / 1ps

module utbd_div #(
  parameter int VALUE_BITS = utbd_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  utbd_pkg::div_ctrl_t           ctrl,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [utbd_pkg::RADIX_W-1:0]  divisor,
  output utbd_pkg::div_stat_t           stat,
  output logic [VALUE_BITS-1:0]         quotient,
  output logic [utbd_pkg::RADIX_W-1:0]  remainder
);

  localparam int CW = $clog2(VALUE_BITS);
  localparam logic [CW-1:0] LAST = CW'(VALUE_BITS - 1);

  logic [VALUE_BITS-1:0]        quot;
  logic [utbd_pkg::RADIX_W-1:0] rem;
  logic [utbd_pkg::RADIX_W-1:0] dvsr;
  logic [CW-1:0]                cnt;
  logic                         busy;
  logic                         done;
  logic                         quot_nz;

  logic [utbd_pkg::RADIX_W:0]   rem_shift;
  logic [utbd_pkg::RADIX_W:0]   rem_sub;
  logic                         fits;
  logic [utbd_pkg::RADIX_W-1:0] rem_next;

  always_comb begin
    rem_shift = {rem, quot[VALUE_BITS-1]};
    rem_sub   = rem_shift - {1'b0, dvsr};
    fits      = rem_shift >= {1'b0, dvsr};
    rem_next  = fits ? rem_sub[utbd_pkg::RADIX_W-1:0] : rem_shift[utbd_pkg::RADIX_W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      quot    <= dividend;
      rem     <= '0;
      dvsr    <= divisor;
      quot_nz <= 1'b0;
    end else if (busy) begin
      quot    <= {quot[VALUE_BITS-2:0], fits};
      rem     <= rem_next;
      quot_nz <= quot_nz | fits;
    end
  end

  assign stat.done    = done;
  assign stat.quot_nz = quot_nz;
  assign quotient     = quot;
  assign remainder    = rem;

endmodule

// File: src/utbd_stack.sv
// Digit stack as a shift line: push at the top, pop from the top.
`timescale 1ns / 1ps

module utbd_stack #(
  parameter int DEPTH = utbd_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  utbd_pkg::stk_ctrl_t          ctrl,
  input  logic [utbd_pkg::CHAR_W-1:0]  din,
  output logic [utbd_pkg::CHAR_W-1:0]  top
);

  logic [utbd_pkg::CHAR_W-1:0] stk [DEPTH];

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      stk[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (ctrl.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

  assign top = stk[0];

endmodule

// File: src/uint_to_base_digits_unit.sv
// Top level: unsigned integer to ASCII digit string in a programmable radix.
//
// Usage:
//   Input channel (in_valid/in_ready, value): one word per conversion. Only the
//   low VALUE_BITS bits of value are used.
//   Output channel (out_valid/out_ready): one word per digit, most significant
//   first. digit_char is '0'-'9' or 'A'-'Z', last_digit flags the final digit,
//   digit_count carries the total digit count on every word.
//   APB port: one register, radix at byte address 0 (reset 10). Values below
//   2 act as 2, above 36 act as 36. Write only while the block is idle.
// Flow:
//   Each digit takes one full pass of the bit-serial divider (one quotient
//   bit per cycle); all N digits are divided out before the N output words
//   are emitted.
//   One conversion at a time: in_ready is high only while idle.
// Reset: synchronous; returns to idle and restores radix to 10.
// Stall: digits wait in the stack; a held out_ready just holds the current
//   word on the outputs.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uint_to_base_digits_unit #(
  parameter int VALUE_BITS = utbd_pkg::VALUE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // APB configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [utbd_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [utbd_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [utbd_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready,
  // input words
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [63:0]                       value,
  // output words
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [utbd_pkg::CHAR_W-1:0]       digit_char,
  output logic                              last_digit,
  output logic [utbd_pkg::COUNT_W-1:0]      digit_count
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state, state_next;

  logic [utbd_pkg::RADIX_W-1:0] radix;
  logic [CNT_W-1:0]             count, count_next;
  logic [CNT_W-1:0]             remain, remain_next;

  utbd_pkg::div_ctrl_t          div_ctrl;
  utbd_pkg::div_stat_t          div_stat;
  logic [VALUE_BITS-1:0]        div_dividend;
  logic [VALUE_BITS-1:0]        div_quot;
  logic [utbd_pkg::RADIX_W-1:0] div_rem;

  utbd_pkg::stk_ctrl_t          stk_ctrl;
  logic [utbd_pkg::CHAR_W-1:0]  stk_top;

  logic in_acc;
  logic out_acc;
  logic cfg_wr;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[2] == utbd_pkg::REG_RADIX);

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= utbd_pkg::RADIX_RESET;
    end else if (cfg_wr) begin
      radix <= pwdata[utbd_pkg::RADIX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == utbd_pkg::REG_RADIX) begin
      prdata = {{(utbd_pkg::APB_DATA_W - utbd_pkg::RADIX_W){1'b0}}, radix};
    end
  end

  // ---------------------------------------------------------------- control
  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_EMIT);
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // the divider takes the fresh value on accept, else the last quotient
  assign div_dividend = in_ready ? value[VALUE_BITS-1:0] : div_quot;

  always_comb begin
    state_next     = state;
    count_next     = count;
    remain_next    = remain;
    div_ctrl.start = 1'b0;
    stk_ctrl.push  = 1'b0;
    stk_ctrl.pop   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          div_ctrl.start = 1'b1;
          count_next     = '0;
          state_next     = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          stk_ctrl.push = 1'b1;
          count_next    = count + 1'b1;
          if (div_stat.quot_nz) begin
            div_ctrl.start = 1'b1;   // next digit from the quotient
          end else begin
            remain_next = count + 1'b1;
            state_next  = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          stk_ctrl.pop = 1'b1;
          remain_next  = remain - 1'b1;
          if (remain == CNT_W'(1)) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      remain <= '0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      remain <= remain_next;
    end
  end

  // ---------------------------------------------------------------- datapath
  utbd_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (div_dividend),
    .divisor   (utbd_pkg::eff_radix(radix)),
    .stat      (div_stat),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // digits arrive least significant first; the stack hands them back reversed
  utbd_stack #(
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk  (clk),
    .ctrl (stk_ctrl),
    .din  (utbd_pkg::to_ascii(div_rem)),
    .top  (stk_top)
  );

  assign digit_char  = stk_top;
  assign last_digit  = (remain == CNT_W'(1));
  assign digit_count = utbd_pkg::COUNT_W'(count);

  // ---------------------------------------------------------------- checks
  `ASSERT_NEVER(a_one_at_a_time, in_ready && out_valid, "input taken while emitting")
  `ASSERT_IMPLIES(a_remain_range, out_valid, (remain != '0) && (remain <= count), "remain out of range")
  `ASSERT_IMPLIES(a_char_range, out_valid, ((digit_char >= 7'd48) && (digit_char <= 7'd57)) || ((digit_char >= 7'd65) && (digit_char <= 7'd90)), "digit char not alphanumeric")
  `ASSERT_NEXT(a_idle_after_last, out_acc && last_digit, in_ready, "not idle after last digit")

endmodule

// File: bench/uint_to_base_digits_checker.sv
// Checker for the radix converter: predicts the digit words and compares them.
`timescale 1ns / 1ps

module uint_to_base_digits_checker import utbd_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  input  logic                  pready,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [63:0]           value,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [CHAR_W-1:0]     digit_char,
  input  logic                  last_digit,
  input  logic [COUNT_W-1:0]    digit_count,
  output int                    fail_count,
  output int                    pending
);

  localparam logic [7:0] ASCII_ZERO = "0";
  localparam logic [7:0] ASCII_A    = "A";
  localparam int         MAX_DIGITS = 64;

  typedef struct packed {
    logic [CHAR_W-1:0]  ch;
    logic               last;
    logic [COUNT_W-1:0] count;
  } digit_word_t;

  digit_word_t        expected_digits[$];
  logic [RADIX_W-1:0] radix;

  function automatic logic [63:0] clamp_base(input logic [RADIX_W-1:0] r);
    logic [63:0] b;
    b = 64'(r);
    if (b < 64'(RADIX_MIN)) b = 64'(RADIX_MIN);
    if (b > 64'(RADIX_MAX)) b = 64'(RADIX_MAX);
    return b;
  endfunction

  function automatic logic [CHAR_W-1:0] ascii_of(input logic [RADIX_W-1:0] d);
    logic [7:0] c;
    if (d < 6'd10) begin
      c = ASCII_ZERO + 8'(d);
    end else begin
      c = ASCII_A + 8'(d) - 8'd10;
    end
    return c[CHAR_W-1:0];
  endfunction

  // remainders come out lsb first; words are queued msb first
  task automatic predict_digits(input logic [63:0] raw);
    logic [63:0]        v;
    logic [63:0]        base;
    logic [RADIX_W-1:0] rem_lsb [MAX_DIGITS];
    int                 n;
    int                 k;
    digit_word_t        w;
    v    = raw & ({64{1'b1}} >> (64 - VALUE_BITS));
    base = clamp_base(radix);
    n    = 0;
    do begin
      rem_lsb[n] = RADIX_W'(v % base);
      n++;
      v = v / base;
    end while (v != 0 && n < MAX_DIGITS);
    for (k = n - 1; k >= 0; k--) begin
      w.ch    = ascii_of(rem_lsb[k]);
      w.last  = (k == 0);
      w.count = COUNT_W'(n);
      expected_digits.push_back(w);
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    radix      = RADIX_RESET;
  end

  always @(posedge clk) begin
    if (rst) begin
      radix = RADIX_RESET;
    end else begin
      if (psel && penable && pwrite && pready &&
          paddr == APB_ADDR_W'({REG_RADIX, 2'b00})) begin
        radix = pwdata[RADIX_W-1:0];
      end
      if (in_valid && in_ready) begin
        predict_digits(value);
      end
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $error("unexpected digit word: digit_char %0d last_digit %0d digit_count %0d",
                 digit_char, last_digit, digit_count);
          fail_count++;
        end else begin
          digit_word_t exp_w;
          exp_w = expected_digits.pop_front();
          if (digit_char !== exp_w.ch) begin
            $error("digit_char: expected %0d, got %0d", exp_w.ch, digit_char);
            fail_count++;
          end
          if (last_digit !== exp_w.last) begin
            $error("last_digit: expected %0d, got %0d", exp_w.last, last_digit);
            fail_count++;
          end
          if (digit_count !== exp_w.count) begin
            $error("digit_count: expected %0d, got %0d", exp_w.count, digit_count);
            fail_count++;
          end
        end
      end
    end
    pending = expected_digits.size();
  end

endmodule

// File: bench/uint_to_base_digits_unit_tb.sv
// Testbench top for the radix converter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module uint_to_base_digits_unit_tb;
  import utbd_pkg::*;

  localparam int VALUE_BITS        = VALUE_BITS_DEF;
  localparam logic [RADIX_W-1:0] DEC_BASE = 6'd10;
  localparam logic [RADIX_W-1:0] HEX_BASE = 6'd16;
  localparam int ITEMS_PER_SETTING = 45;    // three settings per phase, three phases
  localparam int HOLD_CYCLES       = 3000;  // long receiver back-off
  // worst quiet stretch: a 64-digit radix-2 conversion, plus the hold
  localparam int STALL_LIMIT       = 30000;
  localparam int TAIL_CYCLES       = 4300;  // one full 64-digit conversion

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid;
  logic                  in_ready;
  logic [63:0]           value;
  logic                  out_valid;
  logic                  out_ready;
  logic [CHAR_W-1:0]     digit_char;
  logic                  last_digit;
  logic [COUNT_W-1:0]    digit_count;

  int fail_count;
  int pending;

  // idle odds in percent, set per phase by the stimulus
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // bumped by the stimulus; the receiver serves each bump with one long hold
  int hold_requests = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  uint_to_base_digits_unit #(.VALUE_BITS(VALUE_BITS)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .digit_char(digit_char), .last_digit(last_digit), .digit_count(digit_count)
  );

  uint_to_base_digits_checker #(.VALUE_BITS(VALUE_BITS)) checker_i (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .digit_char(digit_char), .last_digit(last_digit), .digit_count(digit_count),
    .fail_count(fail_count), .pending(pending)
  );

  // Offer one input word. Called at a falling edge; returns at the falling
  // edge after acceptance with in_valid still high, so back-to-back words
  // keep valid up without a glitch.
  task automatic send_value(input logic [63:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Drain every digit word, then program the radix over APB.
  // Upper data bits are random; only the low six bits are the register.
  task automatic set_radix(input logic [RADIX_W-1:0] r);
    logic [APB_DATA_W-1:0] data;
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    data                = $urandom();
    data[RADIX_W-1:0]   = r;
    // setup phase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_ADDR_W'({REG_RADIX, 2'b00});
    pwdata  <= data;
    @(negedge clk);
    // access phase
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly random widths so small values dominate; a few all-ones and zero words.
  function automatic logic [63:0] random_value();
    logic [63:0] v;
    int          width;
    int          pick;
    pick = $urandom_range(99);
    v    = {$urandom(), $urandom()};
    if (pick < 4) begin
      v = '1;
    end else if (pick < 8) begin
      v = 64'd0;
    end else begin
      width = $urandom_range(64, 1);
      if (width < 64) v = v & ((64'd1 << width) - 64'd1);
    end
    return v;
  endfunction

  task automatic run_random_phase(input int s_idle, input int r_idle, input bit with_hold);
    int                 cfg;
    int                 n;
    logic [RADIX_W-1:0] r;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    for (cfg = 0; cfg < 3; cfg++) begin
      case ($urandom_range(4))
        0:       r = RADIX_MIN;
        1:       r = DEC_BASE;
        2:       r = HEX_BASE;
        3:       r = RADIX_MAX;
        default: r = RADIX_W'($urandom_range(63));  // may hit the clamped codes
      endcase
      set_radix(r);
      // receiver backs off while the sender keeps offering words
      if (with_hold && cfg == 0) hold_requests++;
      for (n = 0; n < ITEMS_PER_SETTING; n++) begin
        send_value(random_value());
      end
    end
  endtask

  // Receiver: random back-pressure, plus a long hold on request.
  initial begin
    int hold_left;
    int holds_served;
    hold_left    = 0;
    holds_served = 0;
    out_ready    = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if no word moves on any port for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Test completed with failures");
    $finish;
  end

  // Stimulus and verdict.
  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    value    = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // Directed words, first phase's idle odds.
    send_idle_pct = 27;
    recv_idle_pct = 76;
    // reset radix is decimal
    send_value(64'd0);                  // zero gives a lone '0'
    send_value(64'd9);
    send_value(64'd10);
    send_value(64'd10_000_000_000_000_000_000);
    send_value(64'h8000_0000_0000_0000);
    send_value('1);                     // 20 decimal digits
    set_radix(HEX_BASE);
    send_value(64'd0);
    send_value(64'hF);
    send_value(64'h10);
    send_value(64'h0123_4567_89AB_CDEF);
    send_value('1);
    set_radix(RADIX_MIN);
    send_value('1);                     // 64 binary digits, longest run
    send_value(64'd1);
    send_value(64'h8000_0000_0000_0000);
    set_radix(RADIX_MAX);
    send_value('1);
    send_value(64'd35);                 // 'Z'
    send_value(64'd36);
    // radix codes below two act as two, above thirty-six as thirty-six
    set_radix(6'd0);
    send_value(64'd5);
    set_radix(6'd1);
    send_value(64'd6);
    set_radix(6'd37);
    send_value(64'd35 + 64'd36 * 64'd7);
    set_radix(6'd63);
    send_value('1);

    // Random phases: sender-light/receiver-heavy, the reverse, then none
    // with one long receiver hold to back the block up.
    run_random_phase(27, 76, 1'b0);
    run_random_phase(76, 27, 1'b0);
    run_random_phase(0, 0, 1'b1);

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    // catch any stray word after the last expected one
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: uint_to_base_digits_unit.f
+incdir+src
src/utbd_pkg.sv
src/utbd_div.sv
src/utbd_stack.sv
src/uint_to_base_digits_unit.sv
bench/uint_to_base_digits_checker.sv
bench/uint_to_base_digits_unit_tb.sv
